[design/ges_pkg.sv]
package ges_pkg;

  localparam int QFRAC = 16;
  localparam int ACC_W = 48;
  localparam int NUM_W = ACC_W + QFRAC;

  localparam logic [1:0] REG_MATRIX_SIZE = 2'd0;
  localparam logic [1:0] REG_RHS_COUNT   = 2'd1;
  localparam logic [1:0] REG_PIVOT_THR   = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              req_type;
    logic [2:0]        row;
    logic [2:0]        col;
    logic signed [31:0] value;
    logic              last;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [2:0]        row_res;
    logic [1:0]        col_res;
    logic signed [31:0] value_res;
    logic              last_res;
  } res_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [31:0]      den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PV_RD, ST_PV_CMP, ST_PV_CHK,
    ST_SW_RA, ST_SW_RB, ST_SW_WA, ST_SW_WB,
    ST_EL_PIV_RD, ST_EL_PIV,
    ST_EL_F_RD, ST_EL_F_DIV, ST_EL_F_WAIT,
    ST_EL_RB, ST_EL_RA, ST_EL_M1, ST_EL_WR,
    ST_BS_INIT_RD, ST_BS_INIT, ST_BS_RD, ST_BS_M0, ST_BS_M1, ST_BS_ACC,
    ST_BS_DIV, ST_BS_DWAIT,
    ST_OUT_RD, ST_OUT
  } state_t;

endpackage

[design/ges_ram.sv]
module ges_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                      wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ges_qmul.sv]
module ges_qmul import ges_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] q
);

  logic signed [63:0] prod;
  logic signed [63:0] adj;
  logic signed [47:0] shr;

  // truncate toward zero; the product and the saturated result are both registered
  always_comb begin
    adj = prod[63] ? (prod + 64'sd65535) : prod;
    shr = 48'(adj >>> QFRAC);
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (shr > 48'(Q_MAX)) begin
      q <= Q_MAX;
    end else if (shr < 48'(Q_MIN)) begin
      q <= Q_MIN;
    end else begin
      q <= shr[31:0];
    end
  end

endmodule

[design/ges_div.sv]
module ges_div import ges_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]         qm;
  logic [32:0]              rem;
  logic [31:0]              dmag;
  logic                     neg;
  logic                     dzero;
  logic                     busy;
  logic                     done;
  logic [CNT_W-1:0]         cnt;
  logic [32:0]              rem_sh;
  logic                     ge;
  logic signed [31:0]       quo;

  assign rem_sh = {rem[31:0], qm[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_comb begin
    if (dzero) begin
      quo = '0;
    end else if (!neg) begin
      quo = (qm > NUM_W'(Q_MAX)) ? Q_MAX : qm[31:0];
    end else begin
      quo = (qm > NUM_W'(33'h1_0000_0000 >> 1)) ? Q_MIN : -qm[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        qm   <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
        dmag <= req.den[31] ? 32'(-req.den) : 32'(req.den);
        neg  <= req.num[NUM_W-1] ^ req.den[31];
        dzero <= (req.den == '0);
      end else if (busy) begin
        rem <= ge ? (rem_sh - {1'b0, dmag}) : rem_sh;
        qm  <= {qm[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

[design/gaussian_elimination_solver_top.sv]
// channel  | handshake              | payload
// ---------+------------------------+------------------------------
// load     | start, busy            | req   (req_type,row,col,value,last)
// result   | res_valid (strobe)     | res   (status,row_res,col_res,value_res,last_res)
// config   | psel,penable,pwrite    | paddr, pwdata, prdata, pready
//
// a load item is taken while busy is low; the item with last set starts the solve and busy
// stays high until the final result. the solve runs on one multiplier and one
// radix-2 divider over single-port reads of the stores.
// rst is synchronous and clears control state only; the stores hold garbage.
// results are strobed for one cycle and cannot be stalled.
module gaussian_elimination_solver_top import ges_pkg::*; #(
  parameter int N_MAX = 8,
  parameter int R_MAX = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        res_valid,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MAXD = (N_MAX > R_MAX) ? N_MAX : R_MAX;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int CD   = N_MAX * N_MAX;
  localparam int RD   = N_MAX * R_MAX;
  localparam int CAW  = (CD > 1) ? $clog2(CD) : 1;
  localparam int RAW  = (RD > 1) ? $clog2(RD) : 1;

  function automatic logic [CAW-1:0] c_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    c_addr = CAW'(int'(r) * N_MAX + int'(c));
  endfunction

  function automatic logic [RAW-1:0] r_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    r_addr = RAW'(int'(r) * R_MAX + int'(c));
  endfunction

  // config registers
  logic [3:0]  matrix_size;
  logic [2:0]  rhs_count;
  logic [30:0] pivot_threshold;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size     <= 4'd1;
      rhs_count       <= 3'd1;
      pivot_threshold <= 31'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MATRIX_SIZE: matrix_size     <= pwdata[3:0];
        REG_RHS_COUNT:   rhs_count       <= pwdata[2:0];
        REG_PIVOT_THR:   pivot_threshold <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MATRIX_SIZE: prdata = {28'd0, matrix_size};
      REG_RHS_COUNT:   prdata = {29'd0, rhs_count};
      REG_PIVOT_THR:   prdata = {1'b0, pivot_threshold};
      default:         prdata = '0;
    endcase
  end

  logic [CW-1:0] n_eff;
  logic [CW-1:0] r_eff;

  always_comb begin
    if (matrix_size == '0) begin
      n_eff = CW'(1);
    end else if (int'(matrix_size) > N_MAX) begin
      n_eff = CW'(N_MAX);
    end else begin
      n_eff = CW'(matrix_size);
    end
    if (rhs_count == '0) begin
      r_eff = CW'(1);
    end else if (int'(rhs_count) > R_MAX) begin
      r_eff = CW'(R_MAX);
    end else begin
      r_eff = CW'(rhs_count);
    end
  end

  // sequencer state and datapath registers
  state_t state, state_next;
  logic [CW-1:0] k, i, j, p;
  logic          on_rhs;
  logic [31:0]   best;
  logic signed [31:0] piv, f, t1, a_reg, diag;
  logic signed [ACC_W-1:0] acc;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // memories
  logic              c_we, r_we;
  logic [CAW-1:0]    c_waddr, c_raddr;
  logic [RAW-1:0]    r_waddr, r_raddr;
  logic signed [31:0] c_wdata, r_wdata, c_rdata, r_rdata;

  ges_ram #(.W(32), .D(CD)) u_coef (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  ges_ram #(.W(32), .D(RD)) u_rhs (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  logic signed [31:0] mul_a, mul_b, mul_q;

  ges_qmul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .q(mul_q));

  div_req_t div_req;
  div_rsp_t div_rsp;

  ges_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // shared conditions
  logic [CW-1:0] i_inc, j_inc, k_inc, jlim;
  logic          i_end, j_end, k_end, sing;
  logic signed [31:0] x_rdata;
  logic [31:0]   mag;
  logic signed [32:0] el_diff;
  logic signed [31:0] el_val;

  assign i_inc   = i + 1'b1;
  assign j_inc   = j + 1'b1;
  assign k_inc   = k + 1'b1;
  assign jlim    = on_rhs ? r_eff : n_eff;
  assign i_end   = (i_inc == n_eff);
  assign j_end   = (j_inc == jlim);
  assign k_end   = (k_inc == n_eff);
  assign sing    = (best == '0) || (best < {1'b0, pivot_threshold});
  assign x_rdata = on_rhs ? r_rdata : c_rdata;
  assign mag     = c_rdata[31] ? 32'(-c_rdata) : 32'(c_rdata);
  assign el_diff = 33'(a_reg) - 33'(mul_q);

  always_comb begin
    if (el_diff > 33'(Q_MAX)) begin
      el_val = Q_MAX;
    end else if (el_diff < 33'(Q_MIN)) begin
      el_val = Q_MIN;
    end else begin
      el_val = el_diff[31:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (accept && req.last) state_next = ST_PV_RD;
      ST_PV_RD:      state_next = ST_PV_CMP;
      ST_PV_CMP:     state_next = i_end ? ST_PV_CHK : ST_PV_RD;
      ST_PV_CHK: begin
        if (sing) state_next = ST_IDLE;
        else if (p != k) state_next = ST_SW_RA;
        else state_next = ST_EL_PIV_RD;
      end
      ST_SW_RA:      state_next = ST_SW_RB;
      ST_SW_RB:      state_next = ST_SW_WA;
      ST_SW_WA:      state_next = ST_SW_WB;
      ST_SW_WB:      state_next = (j_end && on_rhs) ? ST_EL_PIV_RD : ST_SW_RA;
      ST_EL_PIV_RD:  state_next = ST_EL_PIV;
      ST_EL_PIV:     state_next = k_end ? ST_BS_INIT_RD : ST_EL_F_RD;
      ST_EL_F_RD:    state_next = ST_EL_F_DIV;
      ST_EL_F_DIV:   state_next = ST_EL_F_WAIT;
      ST_EL_F_WAIT:  if (div_rsp.done) state_next = ST_EL_RB;
      ST_EL_RB:      state_next = ST_EL_RA;
      ST_EL_RA:      state_next = ST_EL_M1;
      ST_EL_M1:      state_next = ST_EL_WR;
      ST_EL_WR: begin
        if (j_end && on_rhs) state_next = i_end ? ST_PV_RD : ST_EL_F_RD;
        else state_next = ST_EL_RB;
      end
      ST_BS_INIT_RD: state_next = ST_BS_INIT;
      ST_BS_INIT:    state_next = k_end ? ST_BS_DIV : ST_BS_RD;
      ST_BS_RD:      state_next = ST_BS_M0;
      ST_BS_M0:      state_next = ST_BS_M1;
      ST_BS_M1:      state_next = ST_BS_ACC;
      ST_BS_ACC:     state_next = i_end ? ST_BS_DIV : ST_BS_RD;
      ST_BS_DIV:     state_next = ST_BS_DWAIT;
      ST_BS_DWAIT: begin
        if (div_rsp.done) begin
          state_next = (j_end && k == '0) ? ST_OUT_RD : ST_BS_INIT_RD;
        end
      end
      ST_OUT_RD:     state_next = ST_OUT;
      ST_OUT:        state_next = (i_end && j_end) ? ST_IDLE : ST_OUT_RD;
      default:       state_next = ST_IDLE;
    endcase
  end

  // memory, multiplier and divider controls
  always_comb begin
    c_we    = 1'b0;
    r_we    = 1'b0;
    c_waddr = c_addr(k, j);
    r_waddr = r_addr(k, j);
    c_wdata = x_rdata;
    r_wdata = x_rdata;
    c_raddr = c_addr(i, k);
    r_raddr = r_addr(i, j);
    mul_a   = f;
    mul_b   = x_rdata;
    div_req = '0;
    case (state)
      ST_IDLE: begin
        c_waddr = CAW'(int'(req.row) * N_MAX + int'(req.col));
        r_waddr = RAW'(int'(req.row) * R_MAX + int'(req.col));
        c_wdata = req.value;
        r_wdata = req.value;
        if (accept && int'(req.row) < N_MAX) begin
          c_we = !req.req_type && int'(req.col) < N_MAX;
          r_we = req.req_type && int'(req.col) < R_MAX;
        end
      end
      ST_SW_RA: begin
        c_raddr = c_addr(k, j);
        r_raddr = r_addr(k, j);
      end
      ST_SW_RB: begin
        c_raddr = c_addr(p, j);
        r_raddr = r_addr(p, j);
      end
      ST_SW_WA: begin
        c_we = !on_rhs;
        r_we = on_rhs;
      end
      ST_SW_WB: begin
        c_waddr = c_addr(p, j);
        r_waddr = r_addr(p, j);
        c_wdata = t1;
        r_wdata = t1;
        c_we    = !on_rhs;
        r_we    = on_rhs;
      end
      ST_EL_PIV_RD: c_raddr = c_addr(k, k);
      ST_EL_F_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {ACC_W'(c_rdata), QFRAC'(0)};
        div_req.den   = piv;
      end
      ST_EL_F_WAIT: begin
        c_waddr = c_addr(i, k);
        c_wdata = '0;
        c_we    = div_rsp.done;
      end
      ST_EL_RB: begin
        c_raddr = c_addr(k, j);
        r_raddr = r_addr(k, j);
      end
      ST_EL_RA: begin
        c_raddr = c_addr(i, j);
        r_raddr = r_addr(i, j);
      end
      ST_EL_WR: begin
        c_waddr = c_addr(i, j);
        r_waddr = r_addr(i, j);
        c_wdata = el_val;
        r_wdata = el_val;
        c_we    = !on_rhs;
        r_we    = on_rhs;
      end
      ST_BS_INIT_RD: begin
        c_raddr = c_addr(k, k);
        r_raddr = r_addr(k, j);
      end
      ST_BS_RD: begin
        c_raddr = c_addr(k, i);
        r_raddr = r_addr(i, j);
      end
      ST_BS_M0: begin
        mul_a = c_rdata;
        mul_b = r_rdata;
      end
      ST_BS_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {acc, QFRAC'(0)};
        div_req.den   = diag;
      end
      ST_BS_DWAIT: begin
        r_wdata = div_rsp.quo;
        r_we    = div_rsp.done;
      end
      ST_OUT_RD: r_raddr = r_addr(i, j);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counters and operand registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        k    <= '0;
        i    <= '0;
        p    <= '0;
        best <= '0;
      end
      ST_PV_CMP: begin
        if (mag > best) begin
          best <= mag;
          p    <= i;
        end
        i <= i_inc;
      end
      ST_PV_CHK: begin
        j      <= '0;
        on_rhs <= 1'b0;
      end
      ST_SW_RB: t1 <= x_rdata;
      ST_SW_WB: begin
        if (j_end) begin
          j      <= '0;
          on_rhs <= 1'b1;
        end else begin
          j <= j_inc;
        end
      end
      ST_EL_PIV: begin
        piv    <= c_rdata;
        i      <= k_inc;
        j      <= '0;
        on_rhs <= 1'b1;
      end
      ST_EL_F_WAIT: begin
        f      <= div_rsp.quo;
        j      <= k_inc;
        on_rhs <= 1'b0;
      end
      ST_EL_M1: a_reg <= x_rdata;
      ST_EL_WR: begin
        if (j_end && !on_rhs) begin
          j      <= '0;
          on_rhs <= 1'b1;
        end else if (j_end) begin
          if (i_end) begin
            k    <= k_inc;
            i    <= k_inc;
            p    <= k_inc;
            best <= '0;
          end else begin
            i <= i_inc;
          end
        end else begin
          j <= j_inc;
        end
      end
      ST_BS_INIT: begin
        acc  <= ACC_W'(r_rdata);
        diag <= c_rdata;
        i    <= k_inc;
      end
      ST_BS_ACC: begin
        acc <= acc - ACC_W'(mul_q);
        i   <= i_inc;
      end
      ST_BS_DWAIT: begin
        if (div_rsp.done) begin
          if (j_end) begin
            j <= '0;
            if (k == '0) begin
              i <= '0;
            end else begin
              k <= k - 1'b1;
            end
          end else begin
            j <= j_inc;
          end
        end
      end
      ST_OUT: begin
        if (i_end) begin
          i <= '0;
          j <= j_inc;
        end else begin
          i <= i_inc;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= (state == ST_OUT) || (state == ST_PV_CHK && sing);
    end
    if (state == ST_OUT) begin
      res.status    <= 1'b0;
      res.row_res   <= 3'(i);
      res.col_res   <= 2'(j);
      res.value_res <= r_rdata;
      res.last_res  <= i_end && j_end;
    end else begin
      res.status    <= 1'b1;
      res.row_res   <= '0;
      res.col_res   <= '0;
      res.value_res <= '0;
      res.last_res  <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_solve: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last_res |-> state == ST_IDLE)
    else $error("final item while the solve still runs");

  a_singular_item: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status |-> res.last_res && res.value_res == '0)
    else $error("singular item malformed");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && $past(req.last))
    else $error("solve started without a last item");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import ges_pkg::*;

  localparam int NMX = 8;
  localparam int RMX = 4;
  localparam int IDLE_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        res_valid;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gaussian_elimination_solver_top #(.N_MAX(NMX), .R_MAX(RMX)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .res_valid(res_valid), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the block
  longint coef_mem [NMX*NMX];
  longint rhs_mem [NMX*RMX];
  logic [3:0]  cfg_order;
  logic [2:0]  cfg_rhs;
  logic [30:0] cfg_thresh;

  res_t   solution_q[$];
  int     err_count;
  int     idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return clip32((a * b) / 65536);
  endfunction

  function automatic longint q_div(longint a, longint d);
    if (d == 0) return 0;
    return clip32((a * 65536) / d);
  endfunction

  function automatic longint q_abs(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // elimination with partial pivoting, then back substitution
  function automatic void solve_system();
    int n, r, i, j, k, p;
    longint best, piv, f, s, t;
    res_t e;
    n = (cfg_order == 0) ? 1 : ((cfg_order > NMX) ? NMX : int'(cfg_order));
    r = (cfg_rhs == 0) ? 1 : ((cfg_rhs > RMX) ? RMX : int'(cfg_rhs));
    for (k = 0; k < n; k++) begin
      p = k;
      best = q_abs(coef_mem[k*NMX+k]);
      for (i = k + 1; i < n; i++)
        if (q_abs(coef_mem[i*NMX+k]) > best) begin
          best = q_abs(coef_mem[i*NMX+k]);
          p = i;
        end
      if (best == 0 || best < longint'(cfg_thresh)) begin
        e = '0;
        e.status = 1'b1;
        e.last_res = 1'b1;
        solution_q.push_back(e);
        return;
      end
      if (p != k) begin
        for (j = 0; j < n; j++) begin
          t = coef_mem[k*NMX+j];
          coef_mem[k*NMX+j] = coef_mem[p*NMX+j];
          coef_mem[p*NMX+j] = t;
        end
        for (j = 0; j < r; j++) begin
          t = rhs_mem[k*RMX+j];
          rhs_mem[k*RMX+j] = rhs_mem[p*RMX+j];
          rhs_mem[p*RMX+j] = t;
        end
      end
      piv = coef_mem[k*NMX+k];
      for (i = k + 1; i < n; i++) begin
        f = q_div(coef_mem[i*NMX+k], piv);
        coef_mem[i*NMX+k] = 0;
        for (j = k + 1; j < n; j++)
          coef_mem[i*NMX+j] = clip32(coef_mem[i*NMX+j] - q_mul(f, coef_mem[k*NMX+j]));
        for (j = 0; j < r; j++)
          rhs_mem[i*RMX+j] = clip32(rhs_mem[i*RMX+j] - q_mul(f, rhs_mem[k*RMX+j]));
      end
    end
    for (k = n - 1; k >= 0; k--)
      for (j = 0; j < r; j++) begin
        s = rhs_mem[k*RMX+j];
        for (i = k + 1; i < n; i++)
          s -= q_mul(coef_mem[k*NMX+i], rhs_mem[i*RMX+j]);
        rhs_mem[k*RMX+j] = q_div(s, coef_mem[k*NMX+k]);
      end
    for (j = 0; j < r; j++)
      for (i = 0; i < n; i++) begin
        e.status = 1'b0;
        e.row_res = i[2:0];
        e.col_res = j[1:0];
        e.value_res = rhs_mem[i*RMX+j][31:0];
        e.last_res = (j == r - 1) && (i == n - 1);
        solution_q.push_back(e);
      end
  endfunction

  function automatic void store_element(req_t it);
    if (it.req_type == 1'b0)
      coef_mem[it.row*NMX+it.col] = longint'(it.value);
    else if (it.col < RMX)
      rhs_mem[it.row*RMX+it.col] = longint'(it.value);
    if (it.last)
      solve_system();
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid) begin
      if (solution_q.size() == 0) begin
        $error("unexpected result: %p", res);
        err_count++;
      end else begin
        e = solution_q.pop_front();
        if (res.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, res.status);
          err_count++;
        end
        if (res.row_res !== e.row_res) begin
          $error("row_res: expected %0d actual %0d", e.row_res, res.row_res);
          err_count++;
        end
        if (res.col_res !== e.col_res) begin
          $error("col_res: expected %0d actual %0d", e.col_res, res.col_res);
          err_count++;
        end
        if (res.value_res !== e.value_res) begin
          $error("value_res: expected %0d actual %0d", e.value_res, res.value_res);
          err_count++;
        end
        if (res.last_res !== e.last_res) begin
          $error("last_res: expected %0d actual %0d", e.last_res, res.last_res);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || res_valid || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(req_t it);
    int gap;
    @(negedge clk);
    start = 1'b1;
    req = it;
    do @(posedge clk); while (busy);
    store_element(it);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_solutions();
    @(negedge clk);
    start = 1'b0;
    while (solution_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_MATRIX_SIZE: cfg_order = data[3:0];
      REG_RHS_COUNT:   cfg_rhs = data[2:0];
      REG_PIVOT_THR:   cfg_thresh = data[30:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(int n_raw, int r_raw, logic [31:0] thr);
    drain_solutions();
    reg_write(REG_MATRIX_SIZE, n_raw);
    reg_write(REG_RHS_COUNT, r_raw);
    reg_write(REG_PIVOT_THR, thr);
  endtask

  function automatic logic [31:0] elem_value(int kind, bit diag);
    case (kind)
      0: return diag ? $urandom_range(0, 1) ? 32'sd1 << 19 : -(32'sd1 << 19)
                     : $signed($urandom_range(0, 1 << 19)) - (32'sd1 << 18);
      1: return $urandom();
      default: return $signed($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  // loads a full system in random order and fires the solve
  // kind: 0 well conditioned, 1 full range, 2 tiny values, 3 repeated row
  task automatic load_system(int kind, bit noise);
    req_t items[$];
    req_t it, tmp;
    int n, r, i, j, a, b;
    n = (cfg_order == 0) ? 1 : ((cfg_order > NMX) ? NMX : int'(cfg_order));
    r = (cfg_rhs == 0) ? 1 : ((cfg_rhs > RMX) ? RMX : int'(cfg_rhs));
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++) begin
        it = '0;
        it.row = i;
        it.col = j;
        it.value = elem_value(kind == 3 ? 0 : kind, i == j);
        items.push_back(it);
      end
    for (i = 0; i < n; i++)
      for (j = 0; j < r; j++) begin
        it = '0;
        it.req_type = 1'b1;
        it.row = i;
        it.col = j;
        it.value = elem_value(kind == 3 ? 0 : kind, 1'b0);
        items.push_back(it);
      end
    if (kind == 3 && n > 1) begin
      a = $urandom_range(1, n - 1);
      for (j = 0; j < n; j++)
        items[a*n+j].value = items[j].value;
    end
    for (i = items.size() - 1; i > 0; i--) begin
      a = $urandom_range(0, i);
      tmp = items[i];
      items[i] = items[a];
      items[a] = tmp;
    end
    // move the n coefficient items of row a (here the last shuffle index) to the end
    if (kind == 3 && n > 1) begin
      for (j = 0; j < items.size(); j++)
        if (items[j].req_type == 1'b0 && items[j].row == a) begin
          tmp = items[j];
          items.delete(j);
          items.push_back(tmp);
          j--;
          if (--b == -n) break;
        end
    end
    if (noise) begin
      b = $urandom_range(1, 3);
      for (i = 0; i < b; i++) begin
        it = '0;
        it.req_type = 1'b1;
        it.row = $urandom_range(0, 7);
        it.col = $urandom_range(RMX, 7);
        it.value = $urandom();
        items.insert($urandom_range(0, items.size()), it);
      end
    end
    if (noise && $urandom_range(0, 2) == 0) begin
      it = '0;
      it.req_type = 1'b1;
      it.row = $urandom_range(0, 7);
      it.col = $urandom_range(RMX, 7);
      it.value = $urandom();
      items.push_back(it);
    end
    items[items.size()-1].last = 1'b1;
    foreach (items[i]) send_item(items[i]);
  endtask

  task automatic test_reset_shape();
    load_system(0, 1'b0);
    load_system(2, 1'b0);
  endtask

  task automatic test_directed_extremes();
    set_shape(2, 2, 1);
    load_system(1, 1'b0);
    load_system(3, 1'b0);
    set_shape(0, 0, 0);
    load_system(0, 1'b1);
    set_shape(1, 7, 32'h7fff_ffff);
    load_system(1, 1'b0);
    set_shape(15, 5, 1 << 16);
    load_system(0, 1'b1);
  endtask

  task automatic test_random_systems();
    int kind, done_items, n_use, r_use;
    done_items = 0;
    while (done_items < 330) begin
      if ($urandom_range(0, 9) < 3)
        set_shape($urandom_range(0, 15), $urandom_range(0, 7),
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 300));
      else
        set_shape($urandom_range(1, 4), $urandom_range(1, 2), $urandom_range(0, 16));
      kind = $urandom_range(0, 9);
      kind = (kind < 6) ? 0 : (kind < 8) ? 1 : (kind < 9) ? 3 : 2;
      n_use = (cfg_order == 0) ? 1 : ((cfg_order > NMX) ? NMX : int'(cfg_order));
      r_use = (cfg_rhs == 0) ? 1 : ((cfg_rhs > RMX) ? RMX : int'(cfg_rhs));
      done_items += n_use * (n_use + r_use);
      load_system(kind, $urandom_range(0, 1));
    end
  endtask

  initial begin
    int tail;
    err_count = 0;
    cfg_order = 4'd1;
    cfg_rhs = 3'd1;
    cfg_thresh = 31'd1;
    foreach (coef_mem[i]) coef_mem[i] = 0;
    foreach (rhs_mem[i]) rhs_mem[i] = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_shape();
    test_directed_extremes();
    test_random_systems();

    drain_solutions();
    tail = 0;
    while (tail < 200) begin
      @(posedge clk);
      tail++;
    end
    if (err_count == 0 && solution_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[gaussian_elimination_solver_top.f]
design/ges_pkg.sv
design/ges_ram.sv
design/ges_qmul.sv
design/ges_div.sv
design/gaussian_elimination_solver_top.sv
verif/tb_top.sv
